// ----- hdl/wsfe_pkg.sv -----
// wsfe_pkg: shared types, constants and the base64 character function
// for the WebSocket frame encoder. No dependencies.
`default_nettype none

package wsfe_pkg;

  localparam int unsigned LEN_W  = 30;
  localparam int unsigned BLEN_W = 32;

  localparam logic [7:0] OP_TEXT = 8'h81;
  localparam logic [7:0] OP_BIN  = 8'h82;
  localparam logic [7:0] LEN_16  = 8'h7E;
  localparam logic [7:0] LEN_64  = 8'h7F;
  localparam logic [7:0] PAD     = 8'h3D;

  localparam logic [BLEN_W-1:0] SHORT_MAX = 32'd125;
  localparam logic [BLEN_W-1:0] MED_MAX   = 32'd65535;

  // ceil(2^33 / 3): exact floor division by three for operands below 2^32
  localparam logic [31:0] DIV3_MUL = 32'hAAAA_AAAB;

  localparam logic [3:0] HL_SHORT = 4'd2;
  localparam logic [3:0] HL_MED   = 4'd4;
  localparam logic [3:0] HL_LONG  = 4'd10;
  localparam logic [3:0] LONG_TOP = 4'd9;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             first_in_frame;
    logic [LEN_W-1:0] payload_length;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
    logic       frame_end;
  } out_t;

  // one classified transaction: optional header plus one to four payload bytes
  typedef struct packed {
    logic             hdr;
    logic             tm;
    logic [LEN_W-1:0] plen;
    logic [3:0][7:0]  chars;
    logic [1:0]       last_idx;
    logic             done;
  } cmd_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] e;
    logic [7:0] r;
    e = {2'b00, v};
    if (v < 6'd26) begin
      r = 8'h41 + e;
    end else if (v < 6'd52) begin
      r = 8'h47 + e;
    end else if (v < 6'd62) begin
      r = e - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/wsfe_front.sv -----
// wsfe_front: accepts input transactions, tracks frame and base64 state,
// builds and pushes one command per transaction that carries a payload byte. Depends on wsfe_pkg.
`default_nettype none

module wsfe_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire wsfe_pkg::in_t in_data_i,
  output logic               push_o,
  output wsfe_pkg::cmd_t     cmd_o,
  input  wire logic          full_i
);

  logic                      tm_q;
  logic [wsfe_pkg::LEN_W-1:0] bl_q, bl_d;
  logic [1:0]                ph_q, ph_d;
  logic [3:0]                cy_q, cy_d;

  logic                      accept, first, active, done;
  logic [7:0]                b;
  logic [wsfe_pkg::LEN_W-1:0] plen, cur_bl, nbl;
  logic [1:0]                cur_ph, nph;
  logic [3:0]                cur_cy, ncy;
  logic [3:0][7:0]           chars;
  logic [1:0]                last_idx;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_data_i.data_byte;
  assign first      = in_data_i.first_in_frame;
  assign plen       = in_data_i.payload_length;

  assign cur_bl = first ? plen : bl_q;
  assign cur_ph = first ? 2'd0 : ph_q;
  assign cur_cy = first ? 4'd0 : cy_q;
  assign active = (cur_bl != '0);
  assign nbl    = cur_bl - 1'b1;
  assign done   = (nbl == '0);

  always_comb begin
    chars    = '0;
    last_idx = 2'd0;
    nph      = cur_ph;
    ncy      = cur_cy;
    if (!tm_q) begin
      chars[0] = b;
    end else begin
      case (cur_ph)
        2'd0: begin
          chars[0] = wsfe_pkg::b64_char(b[7:2]);
          ncy      = {2'b00, b[1:0]};
          nph      = 2'd1;
          if (done) begin
            chars[1] = wsfe_pkg::b64_char({b[1:0], 4'b0000});
            chars[2] = wsfe_pkg::PAD;
            chars[3] = wsfe_pkg::PAD;
            last_idx = 2'd3;
          end
        end
        2'd1: begin
          chars[0] = wsfe_pkg::b64_char({cur_cy[1:0], b[7:4]});
          ncy      = b[3:0];
          nph      = 2'd2;
          if (done) begin
            chars[1] = wsfe_pkg::b64_char({b[3:0], 2'b00});
            chars[2] = wsfe_pkg::PAD;
            last_idx = 2'd2;
          end
        end
        default: begin
          chars[0] = wsfe_pkg::b64_char({cur_cy, b[7:6]});
          chars[1] = wsfe_pkg::b64_char(b[5:0]);
          ncy      = 4'd0;
          nph      = 2'd0;
          last_idx = 2'd1;
        end
      endcase
    end
    if (done) begin
      nph = 2'd0;
      ncy = 4'd0;
    end
  end

  always_comb begin
    bl_d = bl_q;
    ph_d = ph_q;
    cy_d = cy_q;
    if (accept && active) begin
      bl_d = nbl;
      ph_d = nph;
      cy_d = ncy;
    end else if (accept && first) begin
      bl_d = '0;
      ph_d = 2'd0;
      cy_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tm_q <= 1'b0;
      bl_q <= '0;
      ph_q <= 2'd0;
      cy_q <= 4'd0;
    end else begin
      if (cfg_we_i) begin
        tm_q <= cfg_wdata_i;
      end
      bl_q <= bl_d;
      ph_q <= ph_d;
      cy_q <= cy_d;
    end
  end

  assign push_o          = accept && active;
  assign cmd_o.hdr       = first;
  assign cmd_o.tm        = tm_q;
  assign cmd_o.plen      = plen;
  assign cmd_o.chars     = chars;
  assign cmd_o.last_idx  = last_idx;
  assign cmd_o.done      = done;

endmodule

`default_nettype wire

// ----- hdl/wsfe_queue.sv -----
// wsfe_queue: short command queue between front and back.
// Depends on wsfe_pkg.
`default_nettype none

module wsfe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire wsfe_pkg::cmd_t cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output wsfe_pkg::cmd_t      head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  wsfe_pkg::cmd_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wsfe_back.sv -----
// wsfe_back: serialises header and payload bytes of each command into the
// output register, one byte per cycle while a command is queued and the output is not stalled. Depends on wsfe_pkg.
`default_nettype none

module wsfe_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           empty_i,
  input  wire wsfe_pkg::cmd_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output wsfe_pkg::out_t      out_data_o
);

  logic [3:0]                  pos_q, pos_d;
  logic [wsfe_pkg::BLEN_W-1:0] blen_q, blen_d;
  logic                        ov_q;
  wsfe_pkg::out_t              od_q;

  logic [wsfe_pkg::LEN_W:0]      sum3;
  logic [62:0]                   prod;
  logic [wsfe_pkg::BLEN_W-1:0]   blen_c;
  logic                          adv, is_short, is_med, is_hdr, last;
  logic [3:0]                    hl, pi_w, sel;
  logic [1:0]                    pi;
  logic [63:0]                   blen64;
  logic [7:0]                    hbyte, obyte;

  // 4 * ceil(len / 3) for text frames
  assign sum3   = {1'b0, head_i.plen} + 31'd2;
  assign prod   = sum3 * wsfe_pkg::DIV3_MUL;
  assign blen_c = head_i.tm ? {prod[62:33], 2'b00} : {2'b00, head_i.plen};
  assign blen_d = (pos_q == 4'd0) ? blen_c : blen_q;

  assign is_short = (blen_q <= wsfe_pkg::SHORT_MAX);
  assign is_med   = (blen_q <= wsfe_pkg::MED_MAX);
  assign hl = is_short ? wsfe_pkg::HL_SHORT : (is_med ? wsfe_pkg::HL_MED : wsfe_pkg::HL_LONG);

  assign is_hdr = head_i.hdr && ((pos_q == 4'd0) || (pos_q < hl));
  assign pi_w   = head_i.hdr ? pos_q - hl : pos_q;
  assign pi     = pi_w[1:0];
  assign last   = !is_hdr && (pi == head_i.last_idx);

  assign sel    = wsfe_pkg::LONG_TOP - pos_q;
  assign blen64 = {32'b0, blen_q};

  always_comb begin
    if (pos_q == 4'd0) begin
      hbyte = head_i.tm ? wsfe_pkg::OP_TEXT : wsfe_pkg::OP_BIN;
    end else if (pos_q == 4'd1) begin
      hbyte = is_short ? blen_q[7:0] : (is_med ? wsfe_pkg::LEN_16 : wsfe_pkg::LEN_64);
    end else if (is_med) begin
      hbyte = (pos_q == 4'd2) ? blen_q[15:8] : blen_q[7:0];
    end else begin
      hbyte = 8'(blen64 >> {sel, 3'b000});
    end
  end

  assign obyte = is_hdr ? hbyte : head_i.chars[pi];
  assign adv   = !empty_i && (!ov_q || out_ready_i);
  assign pop_o = adv && last;
  assign pos_d = adv ? (last ? 4'd0 : pos_q + 4'd1) : pos_q;

  always_ff @(posedge clk_i) begin
    blen_q <= blen_d;
    if (adv) begin
      od_q.out_byte  <= obyte;
      od_q.last_out  <= last;
      od_q.frame_end <= last && head_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      ov_q  <= 1'b0;
    end else begin
      pos_q <= pos_d;
      if (adv) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

`default_nettype wire

// ----- hdl/websocket_frame_encoder_unit.sv -----
// Accepted transactions are queued; their bytes then enter the output register.
// Throughput: one output byte per cycle from the single output register while a command
// is queued and the output is not stalled; a transaction yields 1 to 14 bytes (header
// up to 10); one yielding none is not queued. Input stalls only when the queue is full.
// Reset (asynchronous, active low) clears frame state, queue and output; text_mode = 0.
`default_nettype none

module websocket_frame_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_we_i,
  input  wire logic           cfg_wdata_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire wsfe_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output wsfe_pkg::out_t      out_data_o
);

  logic           push, full, pop, empty;
  wsfe_pkg::cmd_t cmd, head;

  wsfe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .cmd_o       (cmd),
    .full_i      (full)
  );

  wsfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  wsfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hdl/wsfe_checker.sv -----
// wsfe_checker: port-level assertions for the frame encoder, bound to the
// top level. Depends on wsfe_pkg and websocket_frame_encoder_unit.
`default_nettype none

module wsfe_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire wsfe_pkg::out_t out_data_o
);

  logic expect_hdr_q;

  // next output transaction opens a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      expect_hdr_q <= out_data_o.frame_end;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.last_out)
    else $error("frame end without last_out");

  a_frame_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expect_hdr_q |->
      (out_data_o.out_byte == wsfe_pkg::OP_TEXT) ||
      (out_data_o.out_byte == wsfe_pkg::OP_BIN))
    else $error("frame does not open with an opcode byte");

endmodule

bind websocket_frame_encoder_unit wsfe_checker u_wsfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- bench/tb_websocket_frame_encoder_unit.sv -----
// Self-checking bench for websocket_frame_encoder_unit: directed table, then random
// frames under several handshake idling profiles, checked by typed row bytes or an
// in-bench frame predictor. Depends on wsfe_pkg (hdl/wsfe_pkg.sv) and the encoder RTL.
`timescale 1ns / 1ps

module tb_websocket_frame_encoder_unit;

  localparam bit [0:63][7:0] B64_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int N_DIR = 25;

  typedef struct packed {
    bit              mode;
    wsfe_pkg::in_t   item;
    bit              typed;
    logic [3:0]      cnt;
    bit              ends;
    logic [0:5][7:0] bytes;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic in_valid_i;
  logic in_ready_o;
  wsfe_pkg::in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  wsfe_pkg::out_t out_data_o;

  // predictor state
  logic        tm_q;
  logic [29:0] left_q;
  logic [1:0]  phase_q;
  logic [3:0]  carry_q;
  wsfe_pkg::out_t item_bytes[14];
  int          item_n;

  wsfe_pkg::out_t pending_bytes[$];
  bit       mismatch_seen = 1'b0;
  int       stall_pct = 0;
  dir_row_t dir_tbl[N_DIR];

  websocket_frame_encoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    wsfe_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected output byte %0h", out_data_o.out_byte);
        mismatch_seen = 1'b1;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_data_o.out_byte);
          mismatch_seen = 1'b1;
        end
        if (out_data_o.last_out !== want.last_out) begin
          $error("last_out: expected %0b, got %0b", want.last_out, out_data_o.last_out);
          mismatch_seen = 1'b1;
        end
        if (out_data_o.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_data_o.frame_end);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    return B64_ALPHA[v];
  endfunction

  function automatic dir_row_t drow(input bit m, input logic [7:0] d, input bit f,
                                    input logic [29:0] l, input bit t, input logic [3:0] c,
                                    input bit e, input logic [47:0] bs);
    return {m, d, f, l, t, c, e, bs};
  endfunction

  task automatic put_byte(input logic [7:0] v);
    item_bytes[item_n] = {v, 2'b00};
    item_n++;
  endtask

  // frame bytes caused by one accepted transaction; leaves them in item_bytes
  task automatic encode_item(input wsfe_pkg::in_t it);
    logic [63:0] blen;
    logic [7:0]  b;
    bit          done;
    int          k;
    item_n = 0;
    b = it.data_byte;
    if (it.first_in_frame) begin
      left_q  = '0;
      phase_q = '0;
      carry_q = '0;
      if (it.payload_length == '0) return;
      left_q = it.payload_length;
      blen = {34'd0, it.payload_length};
      if (tm_q) blen = ((blen + 64'd2) / 64'd3) * 64'd4;
      put_byte(tm_q ? wsfe_pkg::OP_TEXT : wsfe_pkg::OP_BIN);
      if (blen <= 64'd125) begin
        put_byte(blen[7:0]);
      end else if (blen <= 64'd65535) begin
        put_byte(wsfe_pkg::LEN_16);
        put_byte(blen[15:8]);
        put_byte(blen[7:0]);
      end else begin
        put_byte(wsfe_pkg::LEN_64);
        for (k = 56; k >= 0; k -= 8) put_byte(blen[k +: 8]);
      end
    end else if (left_q == '0) begin
      return;
    end
    left_q = left_q - 30'd1;
    done = (left_q == '0);
    if (!tm_q) begin
      put_byte(b);
    end else begin
      case (phase_q)
        2'd0: begin
          put_byte(b64_sym(b[7:2]));
          carry_q = {2'b00, b[1:0]};
          phase_q = 2'd1;
        end
        2'd1: begin
          put_byte(b64_sym({carry_q[1:0], b[7:4]}));
          carry_q = b[3:0];
          phase_q = 2'd2;
        end
        default: begin
          put_byte(b64_sym({carry_q, b[7:6]}));
          put_byte(b64_sym(b[5:0]));
          carry_q = '0;
          phase_q = 2'd0;
        end
      endcase
      if (done && phase_q == 2'd1) begin
        put_byte(b64_sym({carry_q[1:0], 4'b0000}));
        put_byte(wsfe_pkg::PAD);
        put_byte(wsfe_pkg::PAD);
      end else if (done && phase_q == 2'd2) begin
        put_byte(b64_sym({carry_q, 2'b00}));
        put_byte(wsfe_pkg::PAD);
      end
    end
    if (done) begin
      phase_q = '0;
      carry_q = '0;
    end
    item_bytes[item_n-1].last_out  = 1'b1;
    item_bytes[item_n-1].frame_end = done;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic xfer(input wsfe_pkg::in_t it, input bit typed, input logic [3:0] cnt,
                      input bit ends, input logic [0:5][7:0] bytes, output int produced);
    int i;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    encode_item(it);
    produced = item_n;
    if (typed) begin
      for (i = 0; i < cnt; i++)
        pending_bytes.push_back({bytes[i], i == cnt - 1, (i == cnt - 1) && ends});
    end else begin
      for (i = 0; i < item_n; i++) pending_bytes.push_back(item_bytes[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic gap(input int pct);
    while ($urandom_range(99) < pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // hold off until all frame bytes are out, plus slack for zero-result transactions
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_bytes.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic set_mode(input bit m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    tm_q = m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int snd_pct, input int stl_pct, input int quota);
    int   r;
    int   len;
    int   k;
    int   tot;
    int   n;
    bit   paused;
    wsfe_pkg::in_t it;
    stall_pct = stl_pct;
    tot = 0;
    paused = 1'b0;
    while (tot < quota) begin
      r = $urandom_range(99);
      if (r < 70) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(90, 130) : $urandom_range(1, 12);
        for (k = 0; k < len && tot < quota; k++) begin
          gap(snd_pct);
          it.data_byte      = 8'($urandom_range(255));
          it.first_in_frame = (k == 0);
          it.payload_length = (k == 0) ? 30'(len) : 30'($urandom);
          xfer(it, 1'b0, '0, 1'b0, '0, n);
          tot++;
        end
      end else if (r < 85) begin
        // frame opened with a long length, left unfinished by the next frame
        len = $urandom_range(1, 3);
        for (k = 0; k < len && tot < quota; k++) begin
          gap(snd_pct);
          it.data_byte      = 8'($urandom_range(255));
          it.first_in_frame = (k == 0);
          case ($urandom_range(2))
            0:       it.payload_length = 30'($urandom_range(126, 65535));
            1:       it.payload_length = 30'($urandom_range(65536, 30'h3FFF_FFFF));
            default: it.payload_length = 30'($urandom);
          endcase
          xfer(it, 1'b0, '0, 1'b0, '0, n);
          tot++;
        end
      end else begin
        gap(snd_pct);
        it.data_byte      = 8'($urandom_range(255));
        it.first_in_frame = (r < 92);
        it.payload_length = (r < 92) ? '0 : 30'($urandom);
        xfer(it, 1'b0, '0, 1'b0, '0, n);
        tot++;
      end
      if (!paused && tot >= quota / 2) begin
        paused = 1'b1;
        drain();
      end
    end
  endtask

  initial begin
    int i;
    int n;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    tm_q    = 1'b0;
    left_q  = '0;
    phase_q = '0;
    carry_q = '0;

    dir_tbl[0]  = drow(0, 8'hA5, 1, 30'd1, 1, 3, 1, {8'h82, 8'h01, 8'hA5, 24'h0});
    dir_tbl[1]  = drow(0, 8'h00, 1, 30'd0, 1, 0, 0, 48'h0);
    dir_tbl[2]  = drow(0, 8'h7F, 0, 30'd5, 1, 0, 0, 48'h0);
    dir_tbl[3]  = drow(0, 8'h00, 1, 30'd125, 1, 3, 0, {8'h82, 8'h7D, 8'h00, 24'h0});
    dir_tbl[4]  = drow(0, 8'hFF, 1, 30'd126, 1, 5, 0,
                       {8'h82, 8'h7E, 8'h00, 8'h7E, 8'hFF, 8'h0});
    dir_tbl[5]  = drow(0, 8'h5A, 1, 30'd65535, 1, 5, 0,
                       {8'h82, 8'h7E, 8'hFF, 8'hFF, 8'h5A, 8'h0});
    dir_tbl[6]  = drow(0, 8'h01, 1, 30'd65536, 0, 0, 0, 48'h0);
    dir_tbl[7]  = drow(0, 8'h80, 1, 30'h3FFF_FFFF, 0, 0, 0, 48'h0);
    dir_tbl[8]  = drow(0, 8'h12, 1, 30'd2, 1, 3, 0, {8'h82, 8'h02, 8'h12, 24'h0});
    dir_tbl[9]  = drow(0, 8'h34, 0, 30'h2AAA_AAAA, 1, 1, 1, {8'h34, 40'h0});
    dir_tbl[10] = drow(1, 8'h00, 1, 30'd1, 1, 6, 1,
                       {8'h81, 8'h04, 8'h41, 8'h41, 8'h3D, 8'h3D});
    dir_tbl[11] = drow(1, 8'hFF, 1, 30'd2, 1, 3, 0, {8'h81, 8'h04, 8'h2F, 24'h0});
    dir_tbl[12] = drow(1, 8'hFF, 0, 30'd0, 1, 3, 1, {8'h2F, 8'h38, 8'h3D, 24'h0});
    dir_tbl[13] = drow(1, 8'h4D, 1, 30'd3, 1, 3, 0, {8'h81, 8'h04, 8'h54, 24'h0});
    dir_tbl[14] = drow(1, 8'h61, 0, 30'd0, 1, 1, 0, {8'h57, 40'h0});
    dir_tbl[15] = drow(1, 8'h6E, 0, 30'd0, 1, 2, 1, {8'h46, 8'h75, 32'h0});
    dir_tbl[16] = drow(1, 8'h00, 1, 30'd94, 0, 0, 0, 48'h0);
    dir_tbl[17] = drow(1, 8'hFC, 1, 30'd93, 0, 0, 0, 48'h0);
    dir_tbl[18] = drow(1, 8'hF8, 1, 30'd49151, 0, 0, 0, 48'h0);
    dir_tbl[19] = drow(1, 8'h3B, 1, 30'd49149, 0, 0, 0, 48'h0);
    dir_tbl[20] = drow(1, 8'hAA, 1, 30'h3FFF_FFFF, 0, 0, 0, 48'h0);
    dir_tbl[21] = drow(1, 8'h55, 0, 30'd0, 0, 0, 0, 48'h0);
    dir_tbl[22] = drow(1, 8'h3E, 1, 30'd4, 0, 0, 0, 48'h0);
    dir_tbl[23] = drow(0, 8'h99, 0, 30'd0, 0, 0, 0, 48'h0);
    dir_tbl[24] = drow(1, 8'hFB, 0, 30'd0, 0, 0, 0, 48'h0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: mode changes only once the encoder has gone quiet, even mid-frame
    for (i = 0; i < N_DIR; i++) begin
      if (i == 0 || dir_tbl[i].mode != tm_q) begin
        drain();
        set_mode(dir_tbl[i].mode);
      end
      xfer(dir_tbl[i].item, dir_tbl[i].typed, dir_tbl[i].cnt, dir_tbl[i].ends,
           dir_tbl[i].bytes, n);
    end

    drain();
    set_mode(1'b0);
    run_phase(0, 0, 54);
    drain();
    set_mode(1'b1);
    run_phase(0, 0, 54);
    drain();
    set_mode(1'b0);
    run_phase(72, 0, 54);
    drain();
    set_mode(1'b1);
    run_phase(72, 0, 54);
    drain();
    set_mode(1'b1);
    run_phase(0, 72, 54);
    drain();
    set_mode(1'b0);
    run_phase(0, 72, 54);
    drain();
    set_mode(1'b1);
    run_phase(24, 24, 54);
    drain();
    set_mode(1'b0);
    run_phase(24, 24, 54);

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_bytes.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (!mismatch_seen && pending_bytes.size() == 0) begin
      $display("** websocket_frame_encoder_unit: PASSED **");
    end else begin
      $display("** websocket_frame_encoder_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** websocket_frame_encoder_unit: FAILED **");
    $finish;
  end

endmodule

// ----- websocket_frame_encoder_unit.f -----
hdl/wsfe_pkg.sv
hdl/wsfe_front.sv
hdl/wsfe_queue.sv
hdl/wsfe_back.sv
hdl/websocket_frame_encoder_unit.sv
hdl/wsfe_checker.sv
bench/tb_websocket_frame_encoder_unit.sv
